// ===== rtl/core/hpt_pkg.sv =====
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int ENTRY_W   = 32;
  localparam int REG_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_DIR   = 1'b1;

  typedef logic [3:0][3:0][ENTRY_W-1:0] mat_t;
  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_bank_t;

  localparam cfg_bank_t CFG_RESET = '{
    64'd281474976710656, 64'd0, 64'd65536, 64'd0,
    64'd0, 64'd281474976710656, 64'd0, 64'd65536
  };

endpackage

// ===== rtl/core/hpt_mac.sv =====
// Matrix-vector multiply: registered products, then registered row sums.
module hpt_mac
  import hpt_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AW          = 50
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          mode,
  input  logic signed [COORD_WIDTH-1:0] vx,
  input  logic signed [COORD_WIDTH-1:0] vy,
  input  logic signed [COORD_WIDTH-1:0] vz,
  input  mat_t                          mtx,
  output logic signed [AW-1:0]          acc_o [4]
);

  localparam int PW = ENTRY_W + COORD_WIDTH;

  logic signed [PW-1:0] prod_r [4][3];
  logic                 mode_r;
  logic signed [AW-1:0] acc_nxt [4];

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= mode;
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= PW'($signed(mtx[r][0]) * vx);
        prod_r[r][1] <= PW'($signed(mtx[r][1]) * vy);
        prod_r[r][2] <= PW'($signed(mtx[r][2]) * vz);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc_nxt[r] = AW'($signed(prod_r[r][0][PW-1:FRAC_BITS]))
                 + AW'($signed(prod_r[r][1][PW-1:FRAC_BITS]))
                 + AW'($signed(prod_r[r][2][PW-1:FRAC_BITS]))
                 + ((mode_r == MODE_POINT) ? AW'($signed(mtx[r][3])) : AW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) acc_o[r] <= acc_nxt[r];
    end
  end

endmodule

// ===== rtl/core/hpt_div.sv =====
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
module hpt_div
  import hpt_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AW          = 50
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [AW-1:0]          num,
  input  logic [AW-1:0]          den,
  output logic [COORD_WIDTH:0]   quo,
  output logic                   sat
);

  localparam int QW = COORD_WIDTH + 1;
  localparam int NW = AW + FRAC_BITS;

  logic [NW-1:0] num_ext;
  logic [NW-1:0] num_hi;

  logic [AW-1:0] rem_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [AW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          sat_r [QW+1];

  assign num_ext = {num, {FRAC_BITS{1'b0}}};
  assign num_hi  = num_ext >> QW;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_hi[AW-1:0];
      low_r[0] <= num_ext[QW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= (num_hi >= NW'(den));
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [AW:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1], low_r[k-1][QW-1]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? AW'(trial - {1'b0, den_r[k-1]}) : AW'(trial);
        low_r[k] <= {low_r[k-1][QW-2:0], 1'b0};
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign quo = q_r[QW];
  assign sat = sat_r[QW];

endmodule

// ===== rtl/core/homogeneous_point_transform_top.sv =====
// Homogeneous 4x4 transform of fixed-point 3D vectors, with perspective divide in
// point mode. A transaction is taken every cycle while the output is not stalled;
// results come out in order. The divider resolves one quotient bit per pipeline
// stage; stalling the output freezes the whole pipeline. Matrix registers reset to
// identity; the user must write them only while the pipeline is empty, as the
// block itself does not enforce this.
module homogeneous_point_transform_top
  import hpt_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_w_zero,
  output logic                          out_overflow
);

  localparam int CW  = COORD_WIDTH;
  localparam int SW  = ENTRY_W + CW - FRAC_BITS;
  localparam int AW  = ((SW > ENTRY_W) ? SW : ENTRY_W) + 2;
  localparam int QW  = CW + 1;
  localparam int DL  = QW + 1;
  localparam int NV  = QW + 6;
  localparam int SDW = 6 + 3 * CW;

  cfg_bank_t cfg_r;
  mat_t      mtx;

  logic [NV-1:0] vld_r;
  logic          en;

  logic                 mode1_r;
  logic signed [CW-1:0] x1_r, y1_r, z1_r;
  logic signed [AW-1:0] acc [4];

  logic [AW-1:0]  a_abs_r [3];
  logic [AW-1:0]  d_abs_r;
  logic [SDW-1:0] side4_r;
  logic [SDW-1:0] side4_nxt;
  logic [SDW-1:0] sd_r [DL];

  logic [QW-1:0]  quo [3];
  logic           dsat [3];

  logic [2:0]     neg_nxt;
  logic [CW-1:0]  dres_nxt [3];
  logic [2:0]     dovf_nxt;

  logic           f_point, f_wz, f_dovf;
  logic [2:0]     f_neg;
  logic [CW-1:0]  f_dres [3];
  logic [CW-1:0]  pres [3];
  logic [2:0]     povf;

  logic [CW-1:0]  x_nxt, y_nxt, z_nxt;
  logic           wz_nxt, ovf_nxt;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) cfg_r[i] <= cfg_data;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mtx[r][c] = cfg_r[r * 2 + c / 2][(c % 2) * ENTRY_W +: ENTRY_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_mode;
      x1_r    <= in_x;
      y1_r    <= in_y;
      z1_r    <= in_z;
    end
  end

  hpt_mac #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(CW),
    .AW         (AW)
  ) u_mac (
    .clk  (clk),
    .en   (en),
    .mode (mode1_r),
    .vx   (x1_r),
    .vy   (y1_r),
    .vz   (z1_r),
    .mtx  (mtx),
    .acc_o(acc)
  );

  logic mode2_r, mode3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r <= mode1_r;
      mode3_r <= mode2_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg_nxt[c] = acc[c][AW-1] ^ acc[3][AW-1];
      if (!acc[c][AW-1] && (acc[c][AW-2:CW-1] != '0)) begin
        dres_nxt[c] = {1'b0, {(CW-1){1'b1}}};
        dovf_nxt[c] = 1'b1;
      end else if (acc[c][AW-1] && (acc[c][AW-2:CW-1] != '1)) begin
        dres_nxt[c] = {1'b1, {(CW-1){1'b0}}};
        dovf_nxt[c] = 1'b1;
      end else begin
        dres_nxt[c] = acc[c][CW-1:0];
        dovf_nxt[c] = 1'b0;
      end
    end
    side4_nxt = {(mode3_r == MODE_POINT), (acc[3] == '0), neg_nxt, |dovf_nxt,
                 dres_nxt[2], dres_nxt[1], dres_nxt[0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a_abs_r[c] <= acc[c][AW-1] ? AW'(-acc[c]) : AW'(acc[c]);
      end
      d_abs_r <= acc[3][AW-1] ? AW'(-acc[3]) : AW'(acc[3]);
      side4_r <= side4_nxt;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    hpt_div #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_WIDTH(CW),
      .AW         (AW)
    ) u_div (
      .clk(clk),
      .en (en),
      .num(a_abs_r[c]),
      .den(d_abs_r),
      .quo(quo[c]),
      .sat(dsat[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side4_r;
      for (int k = 1; k < DL; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  always_comb begin
    {f_point, f_wz, f_neg, f_dovf, f_dres[2], f_dres[1], f_dres[0]} = sd_r[DL-1];
    for (int c = 0; c < 3; c++) begin
      logic [QW-1:0] lim;
      logic [QW-1:0] qs;
      lim = f_neg[c] ? {2'b01, {(CW-1){1'b0}}} : {2'b00, {(CW-1){1'b1}}};
      povf[c] = dsat[c] || (quo[c] > lim);
      qs = povf[c] ? lim : quo[c];
      pres[c] = f_neg[c] ? CW'(-qs[CW-1:0]) : qs[CW-1:0];
    end
    if (!f_point) begin
      x_nxt = f_dres[0]; y_nxt = f_dres[1]; z_nxt = f_dres[2];
      wz_nxt = 1'b0;     ovf_nxt = f_dovf;
    end else if (f_wz) begin
      x_nxt = '0;        y_nxt = '0;        z_nxt = '0;
      wz_nxt = 1'b1;     ovf_nxt = 1'b0;
    end else begin
      x_nxt = pres[0];   y_nxt = pres[1];   z_nxt = pres[2];
      wz_nxt = 1'b0;     ovf_nxt = |povf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x        <= x_nxt;
      out_y        <= y_nxt;
      out_z        <= z_nxt;
      out_w_zero   <= wz_nxt;
      out_overflow <= ovf_nxt;
    end
  end

  a_wz_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !out_overflow)
    else $error("w_zero result carries nonzero coordinates or overflow");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction not captured in first stage");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

endmodule
